// File: rtl/core/pcwc_pkg.sv
// Shared types, register codes and CRC byte-step functions for the packet CRC window checker.
`default_nettype none

package pcwc_pkg;

	localparam int unsigned POS_W = 17;
	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	localparam logic [15:0] CRC16_POLY = 16'hA001;
	localparam logic [15:0] CRC16_INIT = 16'hFFFF;
	localparam logic [31:0] CRC32_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC32_INIT = 32'hFFFFFFFF;

	localparam logic [7:0] SIZE_CRC16 = 8'd2;
	localparam logic [7:0] SIZE_CRC32 = 8'd4;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHECKSUM_ENABLE = 2'd0,
		REG_WINDOW_OFFSET   = 2'd1,
		REG_WINDOW_SIZE     = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] computed_crc;
		logic [31:0] stored_crc;
		logic        insert_valid;
		logic        checksum_ok;
		logic        too_short;
	} out_item_t;

	typedef struct packed {
		logic        checksum_enable;
		logic [15:0] window_offset;
		logic [7:0]  window_size;
	} cfg_t;

	// One byte of reflected CRC-16/MODBUS.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// One byte of reflected CRC-32.
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h000000, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC32_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/pcwc_datapath.sv
// Packet state registers and the per-byte CRC, window capture and verdict logic.
`default_nettype none

module pcwc_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pcwc_pkg::cfg_t     cfg,
	input  wire logic               step,
	input  wire pcwc_pkg::in_item_t item,
	output pcwc_pkg::out_item_t     result
);
	import pcwc_pkg::*;

	logic [31:0]      crc_q;
	logic [POS_W-1:0] pos_q;
	logic [31:0]      cap_q;

	logic             size2;
	logic             size4;
	logic [POS_W-1:0] wend;
	logic [POS_W-1:0] rel;
	logic             in_win;
	logic [31:0]      crc_base;
	logic [31:0]      crc_next;
	logic [31:0]      cap_next;
	logic [POS_W:0]   pos_inc;
	logic             short;
	logic [31:0]      computed;

	assign size2 = (cfg.window_size == SIZE_CRC16);
	assign size4 = (cfg.window_size == SIZE_CRC32);
	assign wend  = {1'b0, cfg.window_offset} + {{(POS_W-8){1'b0}}, cfg.window_size};
	assign rel   = pos_q - {1'b0, cfg.window_offset};
	assign in_win = (pos_q >= {1'b0, cfg.window_offset}) && (pos_q < wend);

	// Seed the CRC at the first byte, then advance it unless the byte is in the window
	always_comb begin
		if (pos_q == '0) begin
			crc_base = size4 ? CRC32_INIT : {16'h0000, CRC16_INIT};
		end else begin
			crc_base = crc_q;
		end
		if (in_win) begin
			crc_next = crc_base;
		end else if (size4) begin
			crc_next = crc32_byte(crc_base, item.data_byte);
		end else begin
			crc_next = {16'h0000, crc16_byte(crc_base[15:0], item.data_byte)};
		end
	end

	// Capture the first four window bytes little-endian
	always_comb begin
		cap_next = cap_q;
		if (in_win && (rel[POS_W-1:2] == '0)) begin
			cap_next = cap_q | ({24'h000000, item.data_byte} << {rel[1:0], 3'b000});
		end
	end

	assign pos_inc = {1'b0, pos_q} + {{POS_W{1'b0}}, 1'b1};
	assign short   = pos_inc < {1'b0, wend};

	// Form the result for the last byte
	always_comb begin
		if (size4) begin
			computed = ~crc_next;
		end else if (size2) begin
			computed = {16'h0000, crc_next[15:0]};
		end else begin
			computed = '0;
		end
		if (!cfg.checksum_enable) begin
			result.computed_crc = '0;
			result.stored_crc   = '0;
			result.too_short    = 1'b0;
			result.insert_valid = 1'b0;
			result.checksum_ok  = 1'b1;
		end else begin
			result.computed_crc = computed;
			result.stored_crc   = cap_next;
			result.too_short    = short;
			result.insert_valid = (size2 || size4) && !short;
			if (short) begin
				result.checksum_ok = 1'b0;
			end else if (size2) begin
				result.checksum_ok = (computed[15:0] == cap_next[15:0]);
			end else if (size4) begin
				result.checksum_ok = (computed == cap_next);
			end else begin
				result.checksum_ok = 1'b1;
			end
		end
	end

	// Advance packet state; return to packet start after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= {16'h0000, CRC16_INIT};
			pos_q <= '0;
			cap_q <= '0;
		end else if (step) begin
			if (item.last_byte) begin
				crc_q <= size4 ? CRC32_INIT : {16'h0000, CRC16_INIT};
				pos_q <= '0;
				cap_q <= '0;
			end else begin
				crc_q <= crc_next;
				cap_q <= cap_next;
				if (pos_q != POS_MAX) begin
					pos_q <= pos_inc[POS_W-1:0];
				end
			end
		end
	end

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.last_byte |=> (pos_q == '0) && (cap_q == '0))
		else $error("packet state not cleared after last byte");

	a_pos_advances: assert property (@(posedge clk) disable iff (!arst_n)
		step && !item.last_byte && (pos_q != POS_MAX) |=> pos_q == $past(pos_q) + 1'b1)
		else $error("byte position did not advance");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(pos_q) && $stable(crc_q) && $stable(cap_q))
		else $error("packet state changed without a byte");

endmodule

`default_nettype wire

// File: rtl/core/pcwc_out_reg.sv
// Result register that holds one verdict until the downstream side takes it.
`default_nettype none

module pcwc_out_reg (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire pcwc_pkg::out_item_t load_data,
	output logic                     free,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output pcwc_pkg::out_item_t      out_data
);
	import pcwc_pkg::*;

	logic      valid_q;
	out_item_t data_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// Hold the valid flag until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	// Load the payload only into a free slot
	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= load_data;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/packet_crc_window_checker_top.sv
// Top level: configuration registers, input register, packet datapath and result register.
// A result is registered in the result register as its last byte leaves the input register, then shows on out_data.
// Throughput: one byte per cycle except while a last byte stalls, set by the combinational CRC byte step feeding crc_q.
// A held result stalls bytes only when the next byte in the input register is a last byte.
// Reset clears enable and offset, sets window size to 2 and empties both stages.
// cfg_ready is always high; a write to an unlisted index is taken and ignored.
`default_nettype none

module packet_crc_window_checker_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [pcwc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [pcwc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire pcwc_pkg::in_item_t                  in_data,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output pcwc_pkg::out_item_t                      out_data
);
	import pcwc_pkg::*;

	cfg_t      cfg_q;
	logic      s1_valid;
	in_item_t  s1_item;
	out_item_t result;
	logic      out_free;
	logic      advance;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.checksum_enable <= 1'b0;
			cfg_q.window_offset   <= '0;
			cfg_q.window_size     <= SIZE_CRC16;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CHECKSUM_ENABLE: cfg_q.checksum_enable <= cfg_data[0];
				REG_WINDOW_OFFSET:   cfg_q.window_offset   <= cfg_data;
				REG_WINDOW_SIZE:     cfg_q.window_size     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Advance the input stage unless a last byte meets a full result register
	assign advance  = s1_valid && (!s1_item.last_byte || out_free);
	assign in_ready = !s1_valid || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_ready) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			s1_item <= in_data;
		end
	end

	pcwc_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.step   (advance),
		.item   (s1_item),
		.result (result)
	);

	pcwc_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && s1_item.last_byte),
		.load_data (result),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("held result overwritten");

	a_stall_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !advance |-> s1_item.last_byte && out_valid && !out_ready)
		else $error("input stage stalled without cause");

	a_empty_takes_input: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid |-> in_ready)
		else $error("empty input stage refused a transaction");

endmodule

`default_nettype wire
